// ===== rtl/rect_fill_outline_rasterizer_defines.svh =====
// Assertion macros shared by the rasterizer RTL.
`ifndef RECT_FILL_OUTLINE_RASTERIZER_DEFINES_SVH
`define RECT_FILL_OUTLINE_RASTERIZER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define RFOR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define RFOR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rfor_pkg.sv =====
// Types and constants shared by the rasterizer modules.
`default_nettype none
package rfor_pkg;

    localparam int Q_W         = 24;   // Q15.8 coordinate width
    localparam int FX_W        = 27;   // bound arithmetic width
    localparam int DIMREG_W    = 10;   // canvas size register width
    localparam int CHAR_W      = 8;
    localparam int COORD_W     = 9;    // read column / row width
    localparam int IN_TDATA_W  = 128;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 16;
    localparam int APB_AW      = 4;
    localparam int APB_DW      = 32;

    localparam logic [FX_W-1:0] ONE_Q8 = FX_W'(256);

    typedef logic [1:0] t_req;
    localparam t_req REQ_CLEAR = 2'd0;
    localparam t_req REQ_DRAW  = 2'd1;
    localparam t_req REQ_READ  = 2'd2;

    localparam logic [1:0] REG_CANVAS_W = 2'd0;
    localparam logic [1:0] REG_CANVAS_H = 2'd1;
    localparam logic [1:0] REG_BG_CHAR  = 2'd2;

    localparam logic [CHAR_W-1:0] BG_CHAR_RST = 8'd32;

    typedef struct packed {
        logic load_req;     // latch the accepted request
        logic sweep_init;   // reset the pixel walk, load bounds
        logic sweep_step;   // visit one pixel
        logic rd_issue;     // read one pixel from the canvas
        logic out_load;     // fill the result register
    } t_dp_cmd;

    typedef struct packed {
        t_req req;
        logic size_bad;
        logic rd_in_range;
        logic sweep_last;
        logic out_full;
    } t_dp_stat;

endpackage
`default_nettype wire

// ===== rtl/rfor_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rfor_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

// ===== rtl/rfor_dp.sv =====
// Datapath: request latch, pixel walk, rectangle classifier, canvas RAM, result register.
`default_nettype none
`include "rect_fill_outline_rasterizer_defines.svh"
module rfor_dp #(
    parameter int MAX_DIM = 512
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic [rfor_pkg::IN_TDATA_W-1:0] i_tdata,
    input  wire logic [rfor_pkg::IN_TUSER_W-1:0] i_tuser,
    input  wire logic [rfor_pkg::DIMREG_W-1:0]   i_eff_w,
    input  wire logic [rfor_pkg::DIMREG_W-1:0]   i_eff_h,
    input  wire logic [rfor_pkg::CHAR_W-1:0]     i_bg_char,
    input  wire logic                            i_m_tready,
    input  wire rfor_pkg::t_dp_cmd               i_cmd,
    output rfor_pkg::t_dp_stat                   o_stat,
    output logic                                 o_m_tvalid,
    output logic [rfor_pkg::OUT_TDATA_W-1:0]     o_m_tdata
);
    import rfor_pkg::*;

    localparam int CW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW = 21;

    // latched request
    t_req                r_req;
    logic [Q_W-1:0]      r_rx, r_ry, r_rw, r_rh;
    logic                r_fill;
    logic [CHAR_W-1:0]   r_paint;
    logic [COORD_W-1:0]  r_pcol, r_prow;

    // bounds: inside when lo <= p <= hi, border when p < lob or p > hib
    logic signed [FX_W-1:0] r_xl, r_xh, r_xlb, r_xhb;
    logic signed [FX_W-1:0] r_yl, r_yh, r_ylb, r_yhb;
    logic signed [FX_W-1:0] rx_s, ry_s, rw_s, rh_s, p_s, q_s;

    logic [CW-1:0] r_col, r_row;
    logic [AW-1:0] r_addr, r_base;

    logic               r_out_valid;
    logic               r_out_status;
    logic [CHAR_W-1:0]  r_out_pix;

    logic              inside_x, inside_y, border_x, border_y, paint;
    logic              col_last, row_last, wr_en;
    logic [CHAR_W-1:0] wr_data, rd_data;
    logic [PW-1:0]     rd_addr_full;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req   <= i_tuser;
            r_rx    <= i_tdata[23:0];
            r_ry    <= i_tdata[47:24];
            r_rw    <= i_tdata[71:48];
            r_rh    <= i_tdata[95:72];
            r_fill  <= i_tdata[96];
            r_paint <= i_tdata[104:97];
            r_pcol  <= i_tdata[113:105];
            r_prow  <= i_tdata[122:114];
        end
    end

    assign rx_s = FX_W'($signed(r_rx));
    assign ry_s = FX_W'($signed(r_ry));
    assign rw_s = FX_W'($signed(r_rw));
    assign rh_s = FX_W'($signed(r_rh));

    always_ff @(posedge i_clk) begin
        if (i_cmd.sweep_init) begin
            r_xl  <= rx_s;
            r_xh  <= rx_s + rw_s;
            r_xlb <= rx_s + $signed(ONE_Q8);
            r_xhb <= rx_s + rw_s - $signed(ONE_Q8);
            r_yl  <= ry_s;
            r_yh  <= ry_s + rh_s;
            r_ylb <= ry_s + $signed(ONE_Q8);
            r_yhb <= ry_s + rh_s - $signed(ONE_Q8);
        end
    end

    // pixel walk, row-major, address tracked next to the counters
    assign col_last = (DIMREG_W'(r_col) == i_eff_w - DIMREG_W'(1));
    assign row_last = (DIMREG_W'(r_row) == i_eff_h - DIMREG_W'(1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.sweep_init) begin
            r_col  <= '0;
            r_row  <= '0;
            r_addr <= '0;
            r_base <= '0;
        end else if (i_cmd.sweep_step) begin
            if (col_last) begin
                r_col  <= '0;
                r_row  <= r_row + CW'(1);
                r_base <= r_base + AW'(MAX_DIM);
                r_addr <= r_base + AW'(MAX_DIM);
            end else begin
                r_col  <= r_col + CW'(1);
                r_addr <= r_addr + AW'(1);
            end
        end
    end

    assign p_s = $signed(FX_W'({r_col, 8'h00}));
    assign q_s = $signed(FX_W'({r_row, 8'h00}));

    assign inside_x = (p_s >= r_xl) && (p_s <= r_xh);
    assign inside_y = (q_s >= r_yl) && (q_s <= r_yh);
    assign border_x = (p_s < r_xlb) || (p_s > r_xhb);
    assign border_y = (q_s < r_ylb) || (q_s > r_yhb);
    assign paint    = inside_x && inside_y && (border_x || border_y || r_fill);

    assign wr_en   = i_cmd.sweep_step && ((r_req == REQ_CLEAR) || paint);
    assign wr_data = (r_req == REQ_CLEAR) ? i_bg_char : r_paint;

    assign rd_addr_full = PW'(r_prow) * PW'(MAX_DIM) + PW'(r_pcol);

    rfor_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_canvas (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_addr),
        .i_wdata (wr_data),
        .i_re    (i_cmd.rd_issue),
        .i_raddr (rd_addr_full[AW-1:0]),
        .o_rdata (rd_data)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_status <= (r_req == REQ_DRAW) && o_stat.size_bad;
            r_out_pix    <= ((r_req == REQ_READ) && o_stat.rd_in_range) ? rd_data : '0;
        end
    end

    assign o_stat.req         = r_req;
    assign o_stat.size_bad    = r_rw[Q_W-1] || (r_rw == '0) || r_rh[Q_W-1] || (r_rh == '0);
    assign o_stat.rd_in_range = (DIMREG_W'(r_pcol) < i_eff_w) && (DIMREG_W'(r_prow) < i_eff_h);
    assign o_stat.sweep_last  = col_last && row_last;
    assign o_stat.out_full    = r_out_valid;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_TDATA_W'({r_out_pix, r_out_status});

    `RFOR_ASSERT_IMP(a_walk_addr, i_clk, i_rst_n, i_cmd.sweep_step, r_addr == r_base + AW'(r_col), "walk address out of step with column")
    `RFOR_ASSERT_IMP(a_out_slot, i_clk, i_rst_n, i_cmd.out_load, !r_out_valid || i_m_tready, "result overwrites an untaken result")
endmodule
`default_nettype wire

// ===== rtl/rfor_ctrl.sv =====
// Controller: request sequencing state machine.
`default_nettype none
`include "rect_fill_outline_rasterizer_defines.svh"
module rfor_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_s_tvalid,
    output logic                    o_s_tready,
    input  wire logic               i_m_tready,
    input  wire rfor_pkg::t_dp_stat i_stat,
    output rfor_pkg::t_dp_cmd       o_cmd
);
    import rfor_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SWEEP,
        ST_RESP
    } t_state;

    t_state r_state;

    always_comb begin
        o_cmd = '0;
        case (r_state)
            ST_IDLE: begin
                o_cmd.load_req = i_s_tvalid;
            end
            ST_DECODE: begin
                case (i_stat.req)
                    REQ_CLEAR: o_cmd.sweep_init = 1'b1;
                    REQ_DRAW:  o_cmd.sweep_init = !i_stat.size_bad;
                    REQ_READ:  o_cmd.rd_issue   = i_stat.rd_in_range;
                    default:   o_cmd = '0;
                endcase
            end
            ST_SWEEP: begin
                o_cmd.sweep_step = 1'b1;
            end
            ST_RESP: begin
                o_cmd.out_load = !i_stat.out_full || i_m_tready;
            end
            default: o_cmd = '0;
        endcase
    end

    assign o_s_tready = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            case (r_state)
                ST_IDLE:   if (i_s_tvalid) r_state <= ST_DECODE;
                ST_DECODE: r_state <= o_cmd.sweep_init ? ST_SWEEP : ST_RESP;
                ST_SWEEP:  if (i_stat.sweep_last) r_state <= ST_RESP;
                ST_RESP:   if (o_cmd.out_load) r_state <= ST_IDLE;
                default:   r_state <= ST_IDLE;
            endcase
        end
    end

    `RFOR_ASSERT_NXT(a_sweep_end, i_clk, i_rst_n, (r_state == ST_SWEEP) && i_stat.sweep_last, r_state == ST_RESP, "walk did not end on last pixel")
    `RFOR_ASSERT_NXT(a_read_resp, i_clk, i_rst_n, o_cmd.rd_issue, (r_state == ST_RESP) && (i_stat.req == REQ_READ), "pixel read not followed by result")
endmodule
`default_nettype wire

// ===== rtl/rect_fill_outline_rasterizer.sv =====
// Top level: character canvas painter with APB configuration and stream request/result ports.
`default_nettype none
// Paints a byte canvas of up to MAX_DIM by MAX_DIM pixels held in one RAM.
// A request transfer carries its kind in tuser (0 clear, 1 draw, 2 read).
// Clear writes background_char to every pixel in use; draw classifies each
// pixel against a signed Q15.8 rectangle and writes paint_char to border
// pixels (within 1.0 of an edge) and, when filled is set, interior pixels.
// A draw with a width or height that is not positive leaves the canvas alone
// and returns status 1. Read returns one byte, or zero outside the canvas.
// Every request gives exactly one result transfer. Clear and an accepted
// draw walk every pixel in use, one pixel per cycle through the single RAM
// write port; read, a rejected draw and all other requests skip the walk.
// A new request is taken once the previous one has its result registered,
// even if that result is still waiting downstream. The canvas comes out of
// reset undefined: clear it before reading. Size registers of 0 act as 1,
// values above MAX_DIM act as MAX_DIM. Write registers only while the block
// is idle.
module rect_fill_outline_rasterizer #(
    parameter int MAX_DIM = 512
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // s_axis_tdata, from bit 0: rect_x[24], rect_y[24], rect_width[24],
    // rect_height[24], filled[1], paint_char[8], pixel_col[9], pixel_row[9], zero fill
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  wire logic [rfor_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // s_axis_tuser: req_type[2]
    input  wire logic [rfor_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
    // m_axis_tdata, from bit 0: status[1], pixel_value[8], zero fill
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    output logic [rfor_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    // configuration
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [rfor_pkg::APB_AW-1:0]      paddr,
    input  wire logic [rfor_pkg::APB_DW-1:0]      pwdata,
    output logic [rfor_pkg::APB_DW-1:0]           prdata,
    output logic                                  pready
);
    import rfor_pkg::*;

    logic [DIMREG_W-1:0] r_canvas_w, r_canvas_h;
    logic [CHAR_W-1:0]   r_bg_char;
    logic [DIMREG_W-1:0] eff_w, eff_h;
    logic                cfg_wr;
    logic [1:0]          reg_idx;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_canvas_w <= DIMREG_W'(1);
            r_canvas_h <= DIMREG_W'(1);
            r_bg_char  <= BG_CHAR_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_CANVAS_W: r_canvas_w <= pwdata[DIMREG_W-1:0];
                REG_CANVAS_H: r_canvas_h <= pwdata[DIMREG_W-1:0];
                REG_BG_CHAR:  r_bg_char  <= pwdata[CHAR_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_CANVAS_W: prdata = APB_DW'(r_canvas_w);
            REG_CANVAS_H: prdata = APB_DW'(r_canvas_h);
            REG_BG_CHAR:  prdata = APB_DW'(r_bg_char);
            default:      prdata = '0;
        endcase
    end

    // clamp the size registers to 1..MAX_DIM
    always_comb begin
        if (r_canvas_w == '0) begin
            eff_w = DIMREG_W'(1);
        end else if ((DIMREG_W + 1)'(r_canvas_w) > (DIMREG_W + 1)'(MAX_DIM)) begin
            eff_w = DIMREG_W'(MAX_DIM);
        end else begin
            eff_w = r_canvas_w;
        end
        if (r_canvas_h == '0) begin
            eff_h = DIMREG_W'(1);
        end else if ((DIMREG_W + 1)'(r_canvas_h) > (DIMREG_W + 1)'(MAX_DIM)) begin
            eff_h = DIMREG_W'(MAX_DIM);
        end else begin
            eff_h = r_canvas_h;
        end
    end

    rfor_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_m_tready (m_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    rfor_dp #(
        .MAX_DIM (MAX_DIM)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_tdata    (s_axis_tdata),
        .i_tuser    (s_axis_tuser),
        .i_eff_w    (eff_w),
        .i_eff_h    (eff_h),
        .i_bg_char  (r_bg_char),
        .i_m_tready (m_axis_tready),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_m_tvalid (m_axis_tvalid),
        .o_m_tdata  (m_axis_tdata)
    );
endmodule
`default_nettype wire

// ===== dv/tb_rect_fill_outline_rasterizer.sv =====
// Self-checking bench for the rectangle rasterizer, checked against a local canvas.
`timescale 1ns / 100ps
module tb_rect_fill_outline_rasterizer;
    import rfor_pkg::*;

    localparam int   MAX_DIM   = 512;
    localparam int   FRAC_ONE  = 256;        // 1.0 in Q15.8
    localparam int   RUN_LIMIT = 3_000_000;  // worst run is two full-canvas sweeps plus change
    localparam t_req REQ_NOP   = 2'd3;       // unused code, must change nothing and answer zeros

    // One request as carried by s_axis, fields in their port widths.
    typedef struct {
        t_req                  kind;
        logic signed [Q_W-1:0] rx;
        logic signed [Q_W-1:0] ry;
        logic signed [Q_W-1:0] rw;
        logic signed [Q_W-1:0] rh;
        logic                  filled;
        logic [CHAR_W-1:0]     paint;
        logic [COORD_W-1:0]    col;
        logic [COORD_W-1:0]    row;
    } t_paint_req;

    // One result as carried by m_axis.
    typedef struct {
        logic              status;
        logic [CHAR_W-1:0] pixel;
    } t_paint_rsp;

    // ------------------------------------------------------------------
    // DUT ports
    // ------------------------------------------------------------------
    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic [IN_TUSER_W-1:0]  s_axis_tuser  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   psel          = 1'b0;
    logic                   penable       = 1'b0;
    logic                   pwrite        = 1'b0;
    logic [APB_AW-1:0]      paddr         = '0;
    logic [APB_DW-1:0]      pwdata        = '0;
    logic [APB_DW-1:0]      prdata;
    logic                   pready;

    rect_fill_outline_rasterizer #(
        .MAX_DIM(MAX_DIM)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Canvas model: shadow registers, pixel store, request/result queues
    // ------------------------------------------------------------------
    logic [DIMREG_W-1:0] cfg_width  = DIMREG_W'(1);
    logic [DIMREG_W-1:0] cfg_height = DIMREG_W'(1);
    logic [CHAR_W-1:0]   cfg_bg     = BG_CHAR_RST;
    logic [CHAR_W-1:0]   canvas_q [MAX_DIM*MAX_DIM];   // row*MAX_DIM+col

    t_paint_req  req_fifo[$];        // requests waiting for the driver
    t_paint_rsp  rsp_expected[$];    // results owed by the DUT, oldest first
    int unsigned reqs_issued = 0;
    int unsigned reqs_taken  = 0;
    int unsigned cycle_cnt   = 0;
    bit          failed      = 1'b0;

    // Size register as the sweep sees it: 0 acts as 1, anything above MAX_DIM clips.
    function automatic int eff_size(logic [DIMREG_W-1:0] v);
        if (v == '0) return 1;
        if (v > MAX_DIM) return MAX_DIM;
        return int'(v);
    endfunction

    // Applies one accepted request to the model canvas and returns its result.
    function automatic t_paint_rsp apply_request(t_paint_req rq);
        t_paint_rsp rs;
        int         r, c, w, h;
        longint     x0, y0, wd, ht, px, py;
        bit         on_border;
        w         = eff_size(cfg_width);
        h         = eff_size(cfg_height);
        rs.status = 1'b0;
        rs.pixel  = '0;
        x0        = rq.rx;
        y0        = rq.ry;
        wd        = rq.rw;
        ht        = rq.rh;
        case (rq.kind)
            REQ_CLEAR: begin
                for (r = 0; r < h; r++)
                    for (c = 0; c < w; c++)
                        canvas_q[r*MAX_DIM + c] = cfg_bg;
            end
            REQ_DRAW: begin
                if (wd <= 0 || ht <= 0) begin
                    rs.status = 1'b1;   // rejected, canvas untouched
                end else begin
                    for (r = 0; r < h; r++) begin
                        for (c = 0; c < w; c++) begin
                            px = longint'(c) * FRAC_ONE;
                            py = longint'(r) * FRAC_ONE;
                            // bounds are closed on both sides
                            if (!(px < x0 || x0 + wd < px || py < y0 || y0 + ht < py)) begin
                                on_border = (px - x0 < FRAC_ONE) || (x0 + wd - px < FRAC_ONE) ||
                                            (py - y0 < FRAC_ONE) || (y0 + ht - py < FRAC_ONE);
                                if (on_border || rq.filled)
                                    canvas_q[r*MAX_DIM + c] = rq.paint;
                            end
                        end
                    end
                end
            end
            REQ_READ: begin
                if (int'(rq.col) < w && int'(rq.row) < h)
                    rs.pixel = canvas_q[int'(rq.row)*MAX_DIM + int'(rq.col)];
            end
            default: ;
        endcase
        return rs;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------
    // Every field random; callers overwrite the ones that matter.
    function automatic t_paint_req noise_req(t_req kind);
        t_paint_req rq;
        rq.kind   = kind;
        rq.rx     = Q_W'($urandom());
        rq.ry     = Q_W'($urandom());
        rq.rw     = Q_W'($urandom());
        rq.rh     = Q_W'($urandom());
        rq.filled = 1'($urandom_range(0, 1));
        rq.paint  = CHAR_W'($urandom());
        rq.col    = COORD_W'($urandom());
        rq.row    = COORD_W'($urandom());
        return rq;
    endfunction

    function automatic void add_req(t_paint_req rq);
        req_fifo.push_back(rq);
        reqs_issued++;
    endfunction

    function automatic void add_op(t_req kind);
        add_req(noise_req(kind));
    endfunction

    function automatic void add_draw(int x, int y, int w, int h, logic fill,
                                     logic [CHAR_W-1:0] pc);
        t_paint_req rq;
        rq        = noise_req(REQ_DRAW);
        rq.rx     = Q_W'(x);
        rq.ry     = Q_W'(y);
        rq.rw     = Q_W'(w);
        rq.rh     = Q_W'(h);
        rq.filled = fill;
        rq.paint  = pc;
        add_req(rq);
    endfunction

    function automatic void add_read(int col, int row);
        t_paint_req rq;
        rq     = noise_req(REQ_READ);
        rq.col = COORD_W'(col);
        rq.row = COORD_W'(row);
        add_req(rq);
    endfunction

    // Edge position a few pixels around the canvas, half the time on a whole pixel.
    function automatic int rand_pos(int n);
        int v;
        v = int'($urandom_range(0, (n + 6) * FRAC_ONE)) - 3 * FRAC_ONE;
        if ($urandom_range(0, 1)) v = v & ~(FRAC_ONE - 1);
        return v;
    endfunction

    // Length of at most two pixels or longer, often whole pixels; rounding down may give zero.
    function automatic int rand_len(int n);
        int v;
        if ($urandom_range(0, 3) == 0) v = int'($urandom_range(1, 2 * FRAC_ONE));
        else v = int'($urandom_range(1, (n + 4) * FRAC_ONE));
        if ($urandom_range(0, 1)) v = v & ~(FRAC_ONE - 1);   // may hit zero: rejected
        return v;
    endfunction

    // Rectangle that lands on or near the canvas in use.
    function automatic t_paint_req shaped_draw();
        t_paint_req rq;
        int         w, h;
        w     = eff_size(cfg_width);
        h     = eff_size(cfg_height);
        rq    = noise_req(REQ_DRAW);
        rq.rx = Q_W'(rand_pos(w));
        rq.ry = Q_W'(rand_pos(h));
        rq.rw = Q_W'(rand_len(w));
        rq.rh = Q_W'(rand_len(h));
        return rq;
    endfunction

    function automatic void add_random_req();
        t_paint_req rq;
        int         w, h, pick;
        w    = eff_size(cfg_width);
        h    = eff_size(cfg_height);
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            rq = noise_req(REQ_CLEAR);
        end else if (pick < 48) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                rq = noise_req(REQ_DRAW);   // full-range fields
            end else if (pick == 1) begin
                rq = shaped_draw();
                if ($urandom_range(0, 1)) rq.rw = Q_W'(-int'($urandom_range(0, 4096)));
                else rq.rh = Q_W'(-int'($urandom_range(0, 4096)));
            end else begin
                rq = shaped_draw();
            end
        end else if (pick < 94) begin
            rq = noise_req(REQ_READ);
            // mostly inside the canvas; the rest spans the whole 9-bit range
            if ($urandom_range(0, 7) != 0) begin
                rq.col = COORD_W'($urandom_range(0, w - 1));
                rq.row = COORD_W'($urandom_range(0, h - 1));
            end
        end else begin
            rq = noise_req(REQ_NOP);
        end
        add_req(rq);
    endfunction

    // ------------------------------------------------------------------
    // APB: write, then read back. Only called while the block is idle.
    // ------------------------------------------------------------------
    task automatic set_reg(input logic [1:0] idx, input int val);
        logic [APB_DW-1:0] rb;
        logic [APB_DW-1:0] want;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= APB_DW'(val);
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            REG_CANVAS_W: begin
                cfg_width = DIMREG_W'(val);
                want      = APB_DW'(cfg_width);
            end
            REG_CANVAS_H: begin
                cfg_height = DIMREG_W'(val);
                want       = APB_DW'(cfg_height);
            end
            default: begin
                cfg_bg = CHAR_W'(val);
                want   = APB_DW'(cfg_bg);
            end
        endcase
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rb = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rb !== want) begin
            $error("prdata at 0x%0h: expected 0x%0h, got 0x%0h", {idx, 2'b00}, want, rb);
            failed = 1'b1;
        end
    endtask

    // Sender holds off until every request is taken and every result is back.
    task automatic wait_idle();
        do @(negedge i_clk);
        while (reqs_taken != reqs_issued || rsp_expected.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    // New canvas setting: clear first so every pixel in use is written, then
    // one shaped draw, reads at the corners and just past them, then random traffic.
    task automatic run_phase(input int w_reg, input int h_reg, input int bg, input int n_rand);
        int w, h;
        set_reg(REG_CANVAS_W, w_reg);
        set_reg(REG_CANVAS_H, h_reg);
        set_reg(REG_BG_CHAR, bg);
        w = eff_size(cfg_width);
        h = eff_size(cfg_height);
        add_op(REQ_CLEAR);
        add_req(shaped_draw());
        add_read(0, 0);
        add_read(w - 1, h - 1);
        add_read(w - 1, 0);
        add_read(0, h - 1);
        add_read(w, 0);
        add_read(0, h);
        repeat (n_rand) add_random_req();
        wait_idle();
    endtask

    // ------------------------------------------------------------------
    // Driver: request side, changes at the falling edge
    // ------------------------------------------------------------------
    t_paint_req cur_req;           // request now on s_axis
    logic       req_fire  = 1'b0;  // transfer seen at the last rising edge
    int         drv_gap   = 0;
    bit         drv_burst = 1'b0;  // stretch with no idle cycles

    always @(negedge i_clk) begin
        t_paint_req nxt;
        if (s_axis_tvalid && !req_fire) begin
            // hold the request until it is taken
        end else if (drv_gap != 0) begin
            s_axis_tvalid <= 1'b0;
            drv_gap       <= drv_gap - 1;
        end else if (req_fifo.size() != 0) begin
            nxt           = req_fifo.pop_front();
            cur_req       <= nxt;
            s_axis_tuser  <= nxt.kind;
            s_axis_tdata  <= {5'd0, nxt.row, nxt.col, nxt.paint, nxt.filled,
                              nxt.rh, nxt.rw, nxt.ry, nxt.rx};
            s_axis_tvalid <= 1'b1;
            if ($urandom_range(0, 19) == 0) drv_burst <= !drv_burst;
            drv_gap <= drv_burst ? 0 : $urandom_range(0, 8);
        end else begin
            s_axis_tvalid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: samples at the rising edge, predicts and checks
    // ------------------------------------------------------------------
    int rcv_stall = 0;
    bit rcv_burst = 1'b0;

    always @(negedge i_clk) m_axis_tready <= (rcv_stall == 0);

    always @(posedge i_clk) begin
        t_paint_rsp want;
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > RUN_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            req_fire <= i_rst_n && s_axis_tvalid && s_axis_tready;
            if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
                rsp_expected.push_back(apply_request(cur_req));
                reqs_taken <= reqs_taken + 1;
            end
            if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
                if (rsp_expected.size() == 0) begin
                    $error("unexpected result transfer: status %0d, pixel_value %0d",
                           m_axis_tdata[0], m_axis_tdata[8:1]);
                    failed = 1'b1;
                end else begin
                    want = rsp_expected.pop_front();
                    if (m_axis_tdata[0] !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_axis_tdata[0]);
                        failed = 1'b1;
                    end
                    if (m_axis_tdata[8:1] !== want.pixel) begin
                        $error("pixel_value: expected 0x%0h, got 0x%0h",
                               want.pixel, m_axis_tdata[8:1]);
                        failed = 1'b1;
                    end
                end
                // receiver stall before the next result
                if ($urandom_range(0, 19) == 0) rcv_burst <= !rcv_burst;
                rcv_stall <= rcv_burst ? 0 : $urandom_range(0, 8);
            end else if (rcv_stall != 0) begin
                rcv_stall <= rcv_stall - 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: 1x1 canvas, space background. Reads past the edge answer zero.
        add_op(REQ_CLEAR);
        add_read(0, 0);
        add_read(1, 0);
        add_read(0, 1);
        add_read(511, 511);
        add_op(REQ_NOP);
        wait_idle();

        // Directed pass on a 24x16 canvas, top background value.
        set_reg(REG_CANVAS_W, 24);
        set_reg(REG_CANVAS_H, 16);
        set_reg(REG_BG_CHAR, 255);
        add_op(REQ_CLEAR);
        // filled box at (2,1) size 10x8: column 12 sits exactly on the right edge
        add_draw(2*FRAC_ONE, FRAC_ONE, 10*FRAC_ONE, 8*FRAC_ONE, 1'b1, 8'h41);
        add_read(2, 1);
        add_read(6, 5);
        add_read(12, 9);
        add_read(13, 9);
        // outline hanging off the top left with fractional edges
        add_draw(-384, -128, 1600, 20*FRAC_ONE, 1'b0, 8'h00);
        add_read(4, 7);
        add_read(1, 7);
        add_read(1, 0);
        // non-positive sizes are rejected, canvas untouched
        add_draw(FRAC_ONE, FRAC_ONE, 0, 4*FRAC_ONE, 1'b1, 8'h55);
        add_draw(FRAC_ONE, FRAC_ONE, 4*FRAC_ONE, -FRAC_ONE, 1'b1, 8'h55);
        add_draw(0, 0, -8388608, 8388607, 1'b1, 8'hFF);
        // huge rectangle: its outline misses the canvas, its fill covers all of it
        add_draw(-16*FRAC_ONE, -16*FRAC_ONE, 8388607, 8388607, 1'b0, 8'h11);
        add_draw(-16*FRAC_ONE, -16*FRAC_ONE, 8388607, 8388607, 1'b1, 8'hEE);
        // origin at the top of the range, nothing on the canvas
        add_draw(8388607, 8388607, 8388607, 8388607, 1'b1, 8'h22);
        // narrower than a pixel: every covered pixel is border
        add_draw(5*FRAC_ONE, 3*FRAC_ONE + 64, 128, 6*FRAC_ONE, 1'b0, 8'h7C);
        add_read(5, 4);
        add_read(23, 15);
        add_read(24, 0);
        add_read(0, 16);
        add_op(REQ_NOP);
        add_op(REQ_CLEAR);
        add_read(5, 4);
        wait_idle();

        // Register extremes: widest row, tallest column, zero sizes acting as one.
        run_phase(512, 1, 0, 2);
        run_phase(1, 512, 128, 2);
        run_phase(0, 0, 7, 2);

        // Random traffic on small canvases.
        repeat (3) run_phase($urandom_range(1, 40), $urandom_range(1, 40),
                             $urandom_range(0, 255), 5);

        // Oversized registers clip to the full canvas; one clear, one draw and the corner reads, no random traffic.
        run_phase(1023, 1023, $urandom_range(0, 255), 0);

        repeat (10) @(negedge i_clk);
        if (!failed) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/rfor_pkg.sv
rtl/rfor_ram.sv
rtl/rfor_dp.sv
rtl/rfor_ctrl.sv
rtl/rect_fill_outline_rasterizer.sv
dv/tb_rect_fill_outline_rasterizer.sv
